[rtl/integer_to_decimal_ascii_top_assert.svh]
// Assertion macros for the decimal text converter.
// Used by integer_to_decimal_ascii_top; expects clk_i and rst_ni in scope.
`ifndef INTEGER_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define INTEGER_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define ITDA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itda same-cycle check failed");

// Next-cycle implication under reset.
`define ITDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itda next-cycle check failed");

`endif

[rtl/itda_pkg.sv]
// Package for the decimal text converter: widths, character codes,
// sequencer state type and the datapath command struct. No dependencies.
package itda_pkg;

  localparam int unsigned ValueBits         = 64;
  localparam int unsigned CharBits          = 8;
  localparam int unsigned ValueWidthDefault = 64;

  localparam logic [CharBits-1:0] CharMinus = 8'd45;
  localparam logic [CharBits-1:0] CharZero  = 8'd48;

  // Decimal digits needed for 2^width - 1 (1233/4096 approximates log10(2)).
  function automatic int unsigned num_digits(input int unsigned width);
    return ((width * 1233) >> 12) + 1;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } itda_state_e;

  typedef struct packed {
    logic load;   // take a new magnitude, clear the BCD digits
    logic step;   // one add-3 and shift pass
    logic shift;  // drop the leading digit
  } itda_cmd_t;

endpackage

[rtl/itda_value_if.sv]
// Input channel of the decimal text converter: one integer per transaction.
// Depends on itda_pkg.
interface itda_value_if import itda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/itda_char_if.sv]
// Output channel of the decimal text converter: one character per transaction.
// Depends on itda_pkg.
interface itda_char_if import itda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] char_code;
  logic                last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/itda_cfg_if.sv]
// Configuration write channel of the decimal text converter (signed_mode).
// No dependencies.
interface itda_cfg_if ();
  logic valid;
  logic ready;
  logic signed_mode;

  modport source (output valid, output signed_mode, input ready);
  modport sink   (input valid, input signed_mode, output ready);
endinterface

[rtl/itda_dabble.sv]
// Shift-and-add-3 binary to BCD unit with a digit shifter for readout.
// Depends on itda_pkg for the command struct.
module itda_dabble import itda_pkg::*; #(
  parameter int unsigned ValueWidth = ValueWidthDefault,
  parameter int unsigned NumDigits  = num_digits(ValueWidth)
) (
  input  logic                  clk_i,
  input  logic [ValueWidth-1:0] mag_i,
  input  itda_cmd_t             cmd_i,
  output logic [3:0]            top_digit_o
);

  localparam int unsigned BcdBits = 4 * NumDigits;

  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdBits-1:0]    bcd_q, bcd_d;
  logic [BcdBits-1:0]    adj;

  always_comb begin
    logic [3:0] dig;
    dig = '0;
    for (int i = 0; i < NumDigits; i++) begin
      dig = bcd_q[4*i +: 4];
      adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
    end else if (cmd_i.step) begin
      bcd_d = {adj[BcdBits-2:0], bin_q[ValueWidth-1]};
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_q[BcdBits-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BcdBits-1 -: 4];

endmodule

[rtl/integer_to_decimal_ascii_top.sv]
// Decimal text converter: one integer in, its ASCII digits out, MSB first.
// Sequence: the BCD unit loads the magnitude, then takes in each of its bits
// with an add-3/shift pass; then the digit positions (num_digits(VALUE_WIDTH),
// 20 at 64 bits) are read out, leading zeros dropped, after a minus sign when
// negative; readout waits while the output stalls. One item is in flight at a time.
// Reset: asynchronous, active low; clears control state, signed_mode to 1.
`include "integer_to_decimal_ascii_top_assert.svh"

module integer_to_decimal_ascii_top import itda_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itda_value_if.sink  in_chan,
  itda_char_if.source out_chan,
  itda_cfg_if.sink    cfg_chan
);

  localparam int unsigned NumDigits = num_digits(VALUE_WIDTH);
  localparam int unsigned BitCntW   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  itda_state_e          state_q, state_d;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]   dig_cnt_q, dig_cnt_d;
  logic                 sign_q, sign_d;
  logic                 started_q, started_d;
  logic                 mode_q;
  logic                 out_valid_q;
  logic [CharBits-1:0]  out_char_q;
  logic                 out_last_q;

  logic [VALUE_WIDTH-1:0] raw_val;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg_in;
  logic                   in_acc;
  logic                   slot_free;
  logic                   out_load;
  logic [CharBits-1:0]    out_char;
  logic                   out_last;
  logic [3:0]             top_digit;
  itda_cmd_t              cmd;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_chan.valid) begin
      mode_q <= cfg_chan.signed_mode;
    end
  end

  assign raw_val = in_chan.value[VALUE_WIDTH-1:0];
  assign neg_in  = mode_q & raw_val[VALUE_WIDTH-1];
  // The most negative value negates to itself, which is its unsigned magnitude.
  assign mag     = neg_in ? ({VALUE_WIDTH{1'b0}} - raw_val) : raw_val;

  assign in_chan.ready = (state_q == ST_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign slot_free     = !out_valid_q || out_chan.ready;

  itda_dabble #(
    .ValueWidth (VALUE_WIDTH),
    .NumDigits  (NumDigits)
  ) u_dabble (
    .clk_i       (clk_i),
    .mag_i       (mag),
    .cmd_i       (cmd),
    .top_digit_o (top_digit)
  );

  // Sequencer outputs
  always_comb begin
    cmd      = '0;
    out_load = 1'b0;
    out_char = CharZero + {4'd0, top_digit};
    out_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd.load = in_acc;
      end
      ST_CONV: begin
        cmd.step = 1'b1;
      end
      ST_EMIT: begin
        if (sign_q) begin
          out_load = slot_free;
          out_char = CharMinus;
        end else if (!started_q && top_digit == 4'd0 && dig_cnt_q > DigCntW'(1)) begin
          // drop a leading zero
          cmd.shift = 1'b1;
        end else if (slot_free) begin
          out_load  = 1'b1;
          out_last  = (dig_cnt_q == DigCntW'(1));
          cmd.shift = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    sign_d    = sign_q;
    started_d = started_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d   = ST_CONV;
          bit_cnt_d = BitCntW'(VALUE_WIDTH);
          dig_cnt_d = DigCntW'(NumDigits);
          sign_d    = neg_in;
          started_d = 1'b0;
        end
      end
      ST_CONV: begin
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        if (bit_cnt_q == BitCntW'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sign_q) begin
          if (out_load) begin
            sign_d = 1'b0;
          end
        end else begin
          if (cmd.shift) begin
            dig_cnt_d = dig_cnt_q - DigCntW'(1);
          end
          if (out_load) begin
            started_d = 1'b1;
            if (out_last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      sign_q      <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
      sign_q    <= sign_d;
      started_q <= started_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= out_char;
      out_last_q <= out_last;
    end
  end

  assign out_chan.valid     = out_valid_q;
  assign out_chan.char_code = out_char_q;
  assign out_chan.last_char = out_last_q;

  `ITDA_ASSERT_NEXT(a_load_starts_conv, in_acc, state_q == ST_CONV && bit_cnt_q == BitCntW'(VALUE_WIDTH))
  `ITDA_ASSERT_SAME(a_emit_has_digits, state_q == ST_EMIT, dig_cnt_q != '0)
  `ITDA_ASSERT_SAME(a_minus_not_last, out_valid_q && out_char_q == CharMinus, !out_last_q)

endmodule
